FILE: hdl/slcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcc_pkg
// shared types and fixed constants of the status led colour compositor
// ----------------------------------------------------------------------------
package slcc_pkg;

	localparam int ACT_W     = 3;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 16;
	localparam int HOLD_W    = 16;
	localparam int LVL_W     = 8;

	// request actions
	localparam logic [ACT_W-1:0] ACT_TICK      = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CAN_RX    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CAN_TX    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_HOST      = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SET_ERROR = 3'd4;
	localparam logic [ACT_W-1:0] ACT_SET_WIFI  = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAN_HOLD   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOST_HOLD  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_LVL  = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOST_LVL   = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RX_LVL     = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TX_LVL     = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BOTH_LVL   = 8'd7;

	// background levels
	localparam int WIFI_DIM_LEVEL    = 10;
	localparam int WIFI_BRIGHT_LEVEL = 30;
	localparam int WIFI_DIM_HALF     = (WIFI_DIM_LEVEL / 2 > 8) ? 8 : WIFI_DIM_LEVEL / 2;

	localparam logic [LVL_W-1:0] BG_DIM_RED     = LVL_W'(WIFI_DIM_HALF);
	localparam logic [LVL_W-1:0] BG_DIM_BLUE    = LVL_W'(WIFI_DIM_LEVEL);
	localparam logic [LVL_W-1:0] BG_BRIGHT_BLUE = LVL_W'(WIFI_BRIGHT_LEVEL);
	localparam logic [LVL_W-1:0] BG_STA_RED     = 8'd8;
	localparam logic [LVL_W-1:0] BG_BLINK_BLUE  = 8'd10;
	localparam logic [LVL_W-1:0] BG_AP_RED      = 8'd10;
	localparam logic [LVL_W-1:0] BG_AP_GREEN    = 8'd6;
	localparam logic [LVL_W-1:0] BG_AP_CLI_RED  = 8'd20;
	localparam logic [LVL_W-1:0] BG_AP_CLI_GRN  = 8'd12;
	localparam logic [LVL_W-1:0] LVL_MAX        = 8'd255;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             error_active;
		logic             wifi_enabled;
		logic             station_mode;
		logic             link_connected;
		logic             client_present;
	} item_t;

	typedef struct packed {
		logic [LVL_W-1:0] red;
		logic [LVL_W-1:0] green;
		logic [LVL_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [HOLD_W-1:0] can_hold;
		logic [HOLD_W-1:0] host_hold;
		logic [HOLD_W-1:0] blink_half;
		logic [LVL_W-1:0]  error_level;
		logic [LVL_W-1:0]  host_level;
		logic [LVL_W-1:0]  rx_level;
		logic [LVL_W-1:0]  tx_level;
		logic [LVL_W-1:0]  both_level;
	} cfg_t;

	typedef struct packed {
		logic client;
		logic connected;
		logic station;
		logic enabled;
	} wifi_t;

	// view of the state after a tick, as the renderer needs it
	typedef struct packed {
		logic  error;
		wifi_t wifi;
		logic  blink_on;
		logic  rx_lit;
		logic  tx_lit;
		logic  host_lit;
	} ctx_t;

endpackage

FILE: hdl/slcc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcc interfaces
// request, result and register write channels
// ----------------------------------------------------------------------------
interface slcc_in_if import slcc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic             error_active;
	logic             wifi_enabled;
	logic             station_mode;
	logic             link_connected;
	logic             client_present;

	modport source (output valid, action, error_active, wifi_enabled, station_mode,
		link_connected, client_present, input ready);
	modport sink (input valid, action, error_active, wifi_enabled, station_mode,
		link_connected, client_present, output ready);
endinterface

interface slcc_out_if import slcc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LVL_W-1:0] red;
	logic [LVL_W-1:0] green;
	logic [LVL_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

interface slcc_cfg_if import slcc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/slcc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcc_cfg_regs
// configuration register file with reset defaults
// ----------------------------------------------------------------------------
module slcc_cfg_regs import slcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DAT_W-1:0] wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.can_hold    <= 16'd50;
			cfg_q.host_hold   <= 16'd50;
			cfg_q.blink_half  <= 16'd500;
			cfg_q.error_level <= 8'd40;
			cfg_q.host_level  <= 8'd20;
			cfg_q.rx_level    <= 8'd30;
			cfg_q.tx_level    <= 8'd30;
			cfg_q.both_level  <= 8'd30;
		end else if (wr_en) begin
			case (wr_index)
				REG_CAN_HOLD:   cfg_q.can_hold    <= wr_data;
				REG_HOST_HOLD:  cfg_q.host_hold   <= wr_data;
				REG_BLINK_HALF: cfg_q.blink_half  <= wr_data;
				REG_ERROR_LVL:  cfg_q.error_level <= wr_data[LVL_W-1:0];
				REG_HOST_LVL:   cfg_q.host_level  <= wr_data[LVL_W-1:0];
				REG_RX_LVL:     cfg_q.rx_level    <= wr_data[LVL_W-1:0];
				REG_TX_LVL:     cfg_q.tx_level    <= wr_data[LVL_W-1:0];
				REG_BOTH_LVL:   cfg_q.both_level  <= wr_data[LVL_W-1:0];
				default:        ; // unknown index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/slcc_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcc_state
// hold countdowns, blink phase and status flags
// ----------------------------------------------------------------------------
module slcc_state import slcc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	input  cfg_t  cfg,
	output ctx_t  ctx
);

	logic [HOLD_W-1:0] rx_q, tx_q, host_q, elapsed_q;
	logic              blink_q, error_q;
	wifi_t             wifi_q;

	logic [HOLD_W-1:0] rx_nxt, tx_nxt, host_nxt, elapsed_inc, elapsed_nxt;
	logic              blink_nxt, wrap;

	always_comb begin
		rx_nxt      = (rx_q != '0) ? rx_q - 1'b1 : rx_q;
		tx_nxt      = (tx_q != '0) ? tx_q - 1'b1 : tx_q;
		host_nxt    = (host_q != '0) ? host_q - 1'b1 : host_q;
		elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
		wrap        = (elapsed_inc >= cfg.blink_half);
		elapsed_nxt = wrap ? '0 : elapsed_inc;
		blink_nxt   = blink_q ^ wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q      <= '0;
			tx_q      <= '0;
			host_q    <= '0;
			elapsed_q <= '0;
			blink_q   <= 1'b0;
			error_q   <= 1'b0;
			wifi_q    <= '0;
		end else if (step) begin
			case (item.action)
				ACT_TICK: begin
					rx_q      <= rx_nxt;
					tx_q      <= tx_nxt;
					host_q    <= host_nxt;
					elapsed_q <= elapsed_nxt;
					blink_q   <= blink_nxt;
				end
				ACT_CAN_RX:    rx_q    <= cfg.can_hold;
				ACT_CAN_TX:    tx_q    <= cfg.can_hold;
				ACT_HOST:      host_q  <= cfg.host_hold;
				ACT_SET_ERROR: error_q <= item.error_active;
				ACT_SET_WIFI: begin
					wifi_q.enabled   <= item.wifi_enabled;
					wifi_q.station   <= item.station_mode;
					wifi_q.connected <= item.link_connected;
					wifi_q.client    <= item.client_present;
				end
				default: ; // unused action
			endcase
		end
	end

	// overlays judged on the post-decrement counts
	assign ctx.error    = error_q;
	assign ctx.wifi     = wifi_q;
	assign ctx.blink_on = blink_nxt;
	assign ctx.rx_lit   = (rx_nxt != '0);
	assign ctx.tx_lit   = (tx_nxt != '0);
	assign ctx.host_lit = (host_nxt != '0);

endmodule

FILE: hdl/slcc_render.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcc_render
// wifi background, activity overlays and error override
// ----------------------------------------------------------------------------
module slcc_render import slcc_pkg::*; (
	input  ctx_t ctx,
	input  cfg_t cfg,
	output rgb_t color
);

	function automatic logic [LVL_W-1:0] sat_add(input logic [LVL_W-1:0] a,
		input logic [LVL_W-1:0] b);
		logic [LVL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[LVL_W] ? LVL_MAX : s[LVL_W-1:0];
	endfunction

	rgb_t bg, host_c, can_c;

	always_comb begin
		bg = '0;
		if (ctx.wifi.enabled) begin
			if (ctx.wifi.station) begin
				if (!ctx.wifi.connected) begin
					if (ctx.blink_on) begin
						bg.red  = BG_STA_RED;
						bg.blue = BG_BLINK_BLUE;
					end
				end else if (!ctx.wifi.client) begin
					bg.red  = BG_DIM_RED;
					bg.blue = BG_DIM_BLUE;
				end else begin
					bg.red  = BG_STA_RED;
					bg.blue = BG_BRIGHT_BLUE;
				end
			end else if (!ctx.wifi.client) begin
				bg.red   = BG_AP_RED;
				bg.green = BG_AP_GREEN;
			end else begin
				bg.red   = BG_AP_CLI_RED;
				bg.green = BG_AP_CLI_GRN;
			end
		end

		host_c = bg;
		if (ctx.host_lit) begin
			host_c.red   = sat_add(bg.red, cfg.host_level);
			host_c.green = sat_add(bg.green, cfg.host_level);
			host_c.blue  = sat_add(bg.blue, cfg.host_level);
		end

		can_c = host_c;
		if (ctx.rx_lit && ctx.tx_lit) begin
			can_c.green = sat_add(host_c.green, cfg.both_level);
			can_c.blue  = sat_add(host_c.blue, cfg.both_level);
		end else if (ctx.rx_lit) begin
			can_c.blue  = sat_add(host_c.blue, cfg.rx_level);
		end else if (ctx.tx_lit) begin
			can_c.green = sat_add(host_c.green, cfg.tx_level);
		end

		if (ctx.error) begin
			color.red   = cfg.error_level;
			color.green = '0;
			color.blue  = '0;
		end else begin
			color = can_c;
		end
	end

endmodule

FILE: hdl/status_led_color_compositor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_color_compositor_unit
// status led colour compositor: wifi background, activity overlays, error red
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+-----------------------------------------
//  req      | in  | valid/ready  | action, error_active, wifi_enabled,
//           |     |              | station_mode, link_connected, client_present
//  rsp      | out | valid/ready  | red, green, blue
//  cfg      | in  | valid/ready  | index, data (ready always high)
//
//  one request a cycle while rsp is not stalled; a request is registered, then
//  worked on as the request stage moves on; a tick whose colour differs from the
//  last one sent goes to the result stage and rsp; other requests only update state
//  a stalled result holds rsp and the request stage; req.ready stays high
//  while the request stage can move on in the same cycle
//  arst_n clears all control, the hold counters, flags and last colour (off)
// ----------------------------------------------------------------------------
module status_led_color_compositor_unit import slcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	slcc_in_if.sink    req,
	slcc_out_if.source rsp,
	slcc_cfg_if.sink   cfg
);

	// request stage
	logic  s1_valid_q;
	item_t item_s1;

	// result stage and change detection
	logic  out_valid_q;
	rgb_t  out_q;
	rgb_t  last_q;

	cfg_t  cfg_regs;
	ctx_t  ctx;
	rgb_t  color;
	logic  advance;
	logic  emit;

	// the request stage moves on when the result slot is free or being emptied
	assign advance   = s1_valid_q && (!out_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.action         <= req.action;
			item_s1.error_active   <= req.error_active;
			item_s1.wifi_enabled   <= req.wifi_enabled;
			item_s1.station_mode   <= req.station_mode;
			item_s1.link_connected <= req.link_connected;
			item_s1.client_present <= req.client_present;
		end
	end

	slcc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	slcc_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_regs),
		.ctx    (ctx)
	);

	slcc_render u_render (
		.ctx   (ctx),
		.cfg   (cfg_regs),
		.color (color)
	);

	// only a tick renders, and only a changed colour is sent
	assign emit = advance && (item_s1.action == ACT_TICK) && (color != last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_q      <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				last_q      <= color;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= color;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.red   = out_q.red;
	assign rsp.green = out_q.green;
	assign rsp.blue  = out_q.blue;

endmodule

FILE: hdl/slcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcc_checker
// port level checks on the colour compositor, bound to the top level
// ----------------------------------------------------------------------------
module slcc_checker import slcc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic [ACT_W-1:0] in_action,
	input logic             out_valid,
	input logic             out_ready,
	input logic [LVL_W-1:0] red,
	input logic [LVL_W-1:0] green,
	input logic [LVL_W-1:0] blue
);

	rgb_t sent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= '0;
		end else if (out_valid && out_ready) begin
			sent_q <= {red, green, blue};
		end
	end

	// a stalled result keeps its colour
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({red, green, blue}))
		else $error("result changed while stalled");

	// every colour sent differs from the one before, starting from off
	a_changed_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> {red, green, blue} != sent_q)
		else $error("unchanged colour sent");

	// a fresh result comes from an accepted tick
	a_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_action == ACT_TICK, 2))
		else $error("result without a tick");

endmodule

bind status_led_color_compositor_unit slcc_checker u_slcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.in_action (req.action),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.red       (rsp.red),
	.green     (rsp.green),
	.blue      (rsp.blue)
);
